@@ rtl/tccd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tccd_pkg;

	// Command byte codes.
	localparam logic [7:0] CODE_NONE   = 8'd0;
	localparam logic [7:0] CODE_REST   = 8'd61;
	localparam logic [7:0] CODE_TEMPO  = 8'd62;
	localparam logic [7:0] CODE_PFLOAT = 8'd63;
	localparam logic [7:0] CODE_PVIB   = 8'd64;
	localparam logic [7:0] CODE_PARP   = 8'd65;
	localparam logic [7:0] CODE_PSLIDE = 8'd66;
	localparam logic [7:0] CODE_PDBL   = 8'd67;
	localparam logic [7:0] CODE_PATK   = 8'd68;
	localparam logic [7:0] CODE_PDEC   = 8'd69;

	// Effect byte codes.
	localparam logic [7:0] FX_NONE      = 8'd0;
	localparam logic [7:0] FX_RISE      = 8'd1;
	localparam logic [7:0] FX_FALL      = 8'd2;
	localparam logic [7:0] FX_WOBBLE    = 8'd3;
	localparam logic [7:0] FX_CHORD     = 8'd4;
	localparam logic [7:0] FX_SLIDE_UP  = 8'd5;
	localparam logic [7:0] FX_SLIDE_DN  = 8'd6;
	localparam logic [7:0] FX_TWIN      = 8'd7;
	localparam logic [7:0] FX_RAMP_IN   = 8'd8;
	localparam logic [7:0] FX_RAMP_OUT  = 8'd9;
	localparam logic [7:0] FX_NOFX      = 8'd15;
	localparam logic [5:0] FX_MIX_BASE  = 6'd10;

	// Most events one cell can produce.
	localparam int MAX_EVENTS = 4;
	localparam int EVIDX_W    = $clog2(MAX_EVENTS);

	// Depth of the queue between the decoder and the event sequencer.
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [4:0] {
		KIND_EMPTY    = 5'd0,
		KIND_NOTE     = 5'd1,
		KIND_REST     = 5'd2,
		KIND_SAMPLE   = 5'd3,
		KIND_VOLUME   = 5'd4,
		KIND_FLOAT    = 5'd5,
		KIND_VIBRATO  = 5'd6,
		KIND_ARPEGGIO = 5'd7,
		KIND_SLIDE    = 5'd8,
		KIND_DOUBLE   = 5'd9,
		KIND_ATTACK   = 5'd10,
		KIND_DECAY    = 5'd11,
		KIND_MIX      = 5'd12,
		KIND_NOFX     = 5'd13,
		KIND_PFLOAT   = 5'd14,
		KIND_PVIB     = 5'd15,
		KIND_PARP     = 5'd16,
		KIND_PSLIDE   = 5'd17,
		KIND_PDBL     = 5'd18,
		KIND_PATK     = 5'd19,
		KIND_PDEC     = 5'd20,
		KIND_TEMPO    = 5'd21
	} event_kind_t;

	typedef struct packed {
		logic [7:0] note_command;
		logic [7:0] sample_param;
		logic [7:0] effect;
		logic [1:0] channel;
		logic       from_pattern;
	} cell_t;

	typedef struct packed {
		logic [4:0] event_kind;
		logic [7:0] arg_a;
		logic [7:0] arg_b;
		logic [1:0] channel_out;
		logic       last;
	} result_t;

	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  arg_a;
		logic [7:0]  arg_b;
	} evt_t;

	// All events of one cell, packed from slot 0, with the index of the final one.
	typedef struct packed {
		evt_t [MAX_EVENTS-1:0] evts;
		logic [EVIDX_W-1:0]    last_idx;
		logic [1:0]            channel;
	} bundle_t;

endpackage

`default_nettype wire

@@ rtl/tracker_cell_command_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Beat payload
// cells     in         push / full          pattern_cell (tccd_pkg::cell_t)
// events    out        pop / empty          decoded      (tccd_pkg::result_t)
//
// A cell pushed at one edge is decoded into a bundle of one to four events and
// lands in a two-entry queue at that edge; the sequencer loads it from there into
// its bundle register once free, and the output shows events from that register.
// The sequencer sends one event per beat, so a cell takes one to four output beats,
// and a queued next cell's first event follows directly on the last of the one before.
// Reset is asynchronous and clears the queue and the sequencer; the outputs
// read empty after it. A stalled output fills the queue, and full then holds
// off further cells without losing any that were already taken.

module tracker_cell_command_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  tccd_pkg::cell_t   pattern_cell,
	output logic              empty,
	input  logic              pop,
	output tccd_pkg::result_t decoded
);
	import tccd_pkg::*;

	bundle_t front_bundle;
	bundle_t q_head;
	logic    q_empty;
	logic    q_pop;

	// The front end is a pure decoder: it turns a cell into its ordered events
	// in the same cycle the cell is offered.
	tccd_front u_front (
		.pattern_cell (pattern_cell),
		.bundle       (front_bundle)
	);

	// The queue parts the decoder from the sequencer so that each side can
	// stall on its own; its full flag is the block's backpressure.
	tccd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_bundle),
		.full    (full),
		.pop     (q_pop),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	// The sequencer holds one bundle and hands out its events one beat at a
	// time, marking the final one with last.
	tccd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (decoded)
	);

endmodule

`default_nettype wire

@@ rtl/tccd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tccd_front (
	input  tccd_pkg::cell_t   pattern_cell,
	output tccd_pkg::bundle_t bundle
);
	import tccd_pkg::*;

	evt_t [MAX_EVENTS-1:0] cand;
	logic [MAX_EVENTS-1:0] pres;
	evt_t                  fx_evt;
	evt_t                  prm_evt;
	logic [7:0]            code;
	logic [7:0]            prm;
	logic [7:0]            fx;
	logic [EVIDX_W:0]      pos;

	assign code = pattern_cell.note_command;
	assign prm  = pattern_cell.sample_param;
	assign fx   = pattern_cell.effect;

	// Effect byte of a note cell.
	always_comb begin
		fx_evt = '{kind: KIND_EMPTY, arg_a: 8'd0, arg_b: 8'd0};
		unique case (fx) inside
			FX_RISE:     fx_evt.kind = KIND_FLOAT;
			FX_FALL: begin
				fx_evt.kind  = KIND_FLOAT;
				fx_evt.arg_a = 8'd1;
			end
			FX_WOBBLE:   fx_evt.kind = KIND_VIBRATO;
			FX_CHORD:    fx_evt.kind = KIND_ARPEGGIO;
			FX_SLIDE_UP: fx_evt.kind = KIND_SLIDE;
			FX_SLIDE_DN: begin
				fx_evt.kind  = KIND_SLIDE;
				fx_evt.arg_a = 8'd1;
			end
			FX_TWIN:     fx_evt.kind = KIND_DOUBLE;
			FX_RAMP_IN:  fx_evt.kind = KIND_ATTACK;
			FX_RAMP_OUT: fx_evt.kind = KIND_DECAY;
			FX_NOFX:     fx_evt.kind = KIND_NOFX;
			FX_NONE:     fx_evt.kind = KIND_EMPTY;
			default: begin
				// Every other code mixes in a sample, numbered modulo 64.
				fx_evt.kind  = KIND_MIX;
				fx_evt.arg_a = {2'b00, fx[5:0] - FX_MIX_BASE};
			end
		endcase
	end

	// Parameter-setting commands; the kind follows the code in step.
	always_comb begin
		prm_evt.kind  = event_kind_t'(5'(KIND_PFLOAT) + 5'(code - CODE_PFLOAT));
		prm_evt.arg_a = prm;
		prm_evt.arg_b = fx;
		unique case (code) inside
			CODE_PFLOAT, CODE_PDBL: prm_evt.arg_b = 8'd0;
			CODE_PATK, CODE_PDEC:   prm_evt.arg_a = {4'd0, prm[3:0]};
			default:                prm_evt.arg_b = fx;
		endcase
	end

	always_comb begin
		cand = '0;
		pres = '0;
		if (code < CODE_TEMPO) begin
			pres[0] = (code != CODE_NONE);
			cand[0].kind  = (code == CODE_REST) ? KIND_REST : KIND_NOTE;
			cand[0].arg_a = (code == CODE_REST) ? 8'd0 : code - 8'd1;
			pres[1] = (prm[7:4] != 4'd0);
			cand[1].kind  = KIND_SAMPLE;
			cand[1].arg_a = {4'd0, prm[7:4]};
			pres[2] = (prm[3:0] != 4'd0);
			cand[2].kind  = KIND_VOLUME;
			cand[2].arg_a = {4'd0, prm[3:0]};
			pres[3] = (fx != FX_NONE);
			cand[3] = fx_evt;
		end else if (code == CODE_TEMPO) begin
			pres[0] = pattern_cell.from_pattern && (prm != 8'd0);
			cand[0].kind  = KIND_TEMPO;
			cand[0].arg_a = prm;
		end else if (code <= CODE_PDEC) begin
			pres[0] = 1'b1;
			cand[0] = prm_evt;
		end
	end

	// Pack the present events towards slot 0, keeping their order.
	always_comb begin
		bundle         = '0;
		bundle.channel = pattern_cell.channel;
		pos            = '0;
		for (int i = 0; i < MAX_EVENTS; i++) begin
			if (pres[i]) begin
				bundle.evts[pos[EVIDX_W-1:0]] = cand[i];
				pos = pos + 1'b1;
			end
		end
		// A cell with nothing to say still yields one empty event in slot 0.
		bundle.last_idx = (pos == '0) ? '0 : EVIDX_W'(pos - 1'b1);
	end

endmodule

`default_nettype wire

@@ rtl/tccd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tccd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tccd_pkg::bundle_t wr_data,
	output logic              full,
	input  logic              pop,
	output tccd_pkg::bundle_t rd_data,
	output logic              empty
);
	import tccd_pkg::*;

	bundle_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/tccd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tccd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  tccd_pkg::bundle_t q_head,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output tccd_pkg::result_t result
);
	import tccd_pkg::*;

	bundle_t            bnd_q;
	logic [EVIDX_W-1:0] idx_q;
	logic               busy_q;
	logic               at_last;
	logic               advance;
	logic               load;
	evt_t               cur;

	assign at_last = (idx_q == bnd_q.last_idx);
	assign advance = pop && busy_q;
	// A new bundle comes in as soon as the slot is free or its last beat leaves.
	assign load    = !q_empty && (!busy_q || (advance && at_last));
	assign q_pop   = load;
	assign empty   = !busy_q;
	assign cur     = bnd_q.evts[idx_q];

	assign result.event_kind  = cur.kind;
	assign result.arg_a       = cur.arg_a;
	assign result.arg_b       = cur.arg_b;
	assign result.channel_out = bnd_q.channel;
	assign result.last        = at_last;

	always_ff @(posedge clk) begin
		if (load) begin
			bnd_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance && at_last) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// The beat index never runs past the final event of the bundle.
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= bnd_q.last_idx))
		else $error("event index beyond end of bundle");

	// An empty event is only ever the sole event of its cell.
	a_empty_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cur.kind == KIND_EMPTY) |-> (bnd_q.last_idx == '0))
		else $error("empty event inside a multi-event bundle");

	// Taking the last beat with nothing queued leaves the output empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && at_last && q_empty) |=> empty)
		else $error("output not empty after final beat drained");

	// A beat that is not the last moves on to the next slot of the same bundle.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !at_last) |=> (busy_q && idx_q == $past(idx_q) + 1'b1))
		else $error("event index did not step");

endmodule

`default_nettype wire
